### src/status_freshness_watchdog_table_unit_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the status freshness watchdog table
// Shared helpers that wrap concurrent assertions on the local clock and reset.
// ---------------------------------------------------------------------------
`ifndef STATUS_FRESHNESS_WATCHDOG_TABLE_UNIT_DEFINES_SVH
`define STATUS_FRESHNESS_WATCHDOG_TABLE_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SFWT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfwt: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SFWT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfwt: next-cycle check failed");

`endif

### src/sfwt_pkg.sv
// ---------------------------------------------------------------------------
// sfwt_pkg
// Fixed field widths, codes and the result type of the freshness table.
// ---------------------------------------------------------------------------
package sfwt_pkg;

    // Field widths fixed by the interface.
    localparam int NOW_W      = 32;
    localparam int MODE_W     = 4;
    localparam int FLAG_W     = 2;
    localparam int TIMEOUT_W  = 32;
    localparam int MASK_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 8;

    // Four status flags per mode, and the mode numbers the mask can reach.
    localparam int FLAGS_PER_MODE = 4;
    localparam int MODE_LIMIT     = 16;

    // Reset value of the timeout register.
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 32'd1000;

    // Item kinds carried on tuser.
    localparam logic ACT_REPORT = 1'b0;
    localparam logic ACT_AGE    = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODE_PRESENT = 2'd1;

    // One result, available in the lowest bit.
    typedef struct packed {
        logic all_ready;
        logic mode_known;
        logic continuable;
        logic stable;
        logic active;
        logic available;
    } t_result;

endpackage

### src/sfwt_age_unit.sv
// ---------------------------------------------------------------------------
// sfwt_age_unit
// Time stamp memory with one write and one registered read port, followed
// by the elapsed-time compare that decides whether an entry has expired.
// ---------------------------------------------------------------------------
module sfwt_age_unit #(
    parameter int ENTRIES     = 64,
    parameter int STAMP_WIDTH = 32,
    localparam int IDX_W      = $clog2(ENTRIES)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_wr_en,
    input  logic [IDX_W-1:0]                i_wr_idx,
    input  logic [STAMP_WIDTH-1:0]          i_wr_stamp,
    input  logic                            i_rd_en,
    input  logic [IDX_W-1:0]                i_rd_idx,
    input  logic [STAMP_WIDTH-1:0]          i_now,
    input  logic [sfwt_pkg::TIMEOUT_W-1:0]  i_timeout,
    output logic                            o_chk_vld,
    output logic [IDX_W-1:0]                o_chk_idx,
    output logic                            o_chk_old
);

    localparam int CMP_W = (STAMP_WIDTH > sfwt_pkg::TIMEOUT_W) ?
                           STAMP_WIDTH : sfwt_pkg::TIMEOUT_W;

    logic [STAMP_WIDTH-1:0] r_stamp_mem [ENTRIES];
    logic [STAMP_WIDTH-1:0] r_rd_data;
    logic [IDX_W-1:0]       r_chk_idx;
    logic                   r_chk_vld;
    logic [STAMP_WIDTH-1:0] w_elapsed;

    // Stamp memory: one write and one read per cycle, read data registered.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_stamp_mem[i_wr_idx] <= i_wr_stamp;
        end
        if (i_rd_en) begin
            r_rd_data <= r_stamp_mem[i_rd_idx];
        end
        r_chk_idx <= i_rd_idx;
    end

    // The read data is valid in the cycle after the request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk_vld <= 1'b0;
        end else begin
            r_chk_vld <= i_rd_en;
        end
    end

    // Elapsed time wraps at the stamp width; expiry is a strict compare.
    assign w_elapsed = i_now - r_rd_data;
    assign o_chk_old = CMP_W'(w_elapsed) > CMP_W'(i_timeout);
    assign o_chk_vld = r_chk_vld;
    assign o_chk_idx = r_chk_idx;

endmodule

### src/status_freshness_watchdog_table_unit.sv
// ---------------------------------------------------------------------------
// status_freshness_watchdog_table_unit
// Per-mode table of four status flags with freshness tracking and aging.
//
//   Channel   Direction  Handshake                    Carries
//   s_axis    in         s_axis_tvalid/s_axis_tready  one report or age check
//   m_axis    out        m_axis_tvalid/m_axis_tready  one status result
//   cfg       in         i_cfg_valid/o_cfg_ready      register index and data
//
// A report is accepted in the idle state, and its result is loaded from done.
// An age check passes through the scan, drain and done states: the stamp memory
// has a single read port, so the scan visits one entry per cycle.
// Reset clears all fresh and value bits at once; no clearing pass is needed.
// A stalled output holds the result; the next item is still accepted and
// waits in the done state until the output register frees.
// ---------------------------------------------------------------------------
`include "status_freshness_watchdog_table_unit_defines.svh"

module status_freshness_watchdog_table_unit #(
    parameter int NUM_MODES   = 16,
    parameter int STAMP_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input items.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // now [31:0], mode_id [35:32], flag_sel [37:36], flag_value [38]
    input  logic [sfwt_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // action [0]
    input  logic                              s_axis_tuser,
    // Results.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // available [0], active [1], stable [2], continuable [3],
    // mode_known [4], all_ready [5]
    output logic [sfwt_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // Configuration writes.
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [sfwt_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [sfwt_pkg::TIMEOUT_W-1:0]    i_cfg_wdata
);

    localparam int NUM_LIVE = (NUM_MODES < sfwt_pkg::MODE_LIMIT) ?
                              NUM_MODES : sfwt_pkg::MODE_LIMIT;
    localparam int ENTRIES  = NUM_LIVE * sfwt_pkg::FLAGS_PER_MODE;
    localparam int IDX_W    = $clog2(ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
    localparam logic [sfwt_pkg::MODE_W:0] LIVE_LIMIT = (sfwt_pkg::MODE_W + 1)'(NUM_LIVE);

    // Sequencer states.
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]                        r_state, n_state;
    logic [IDX_W-1:0]                  r_scan_idx, n_scan_idx;
    logic [sfwt_pkg::TIMEOUT_W-1:0]    r_timeout;
    logic [sfwt_pkg::MASK_W-1:0]       r_mode_present;
    logic [sfwt_pkg::MODE_W-1:0]       r_mode_id;
    logic [STAMP_WIDTH-1:0]            r_now;
    logic [ENTRIES-1:0]                r_fresh;
    logic [ENTRIES-1:0]                r_value;
    logic                              r_out_valid;
    sfwt_pkg::t_result                 r_out;
    sfwt_pkg::t_result                 w_result;

    logic                              w_in_accept;
    logic                              w_out_load;
    logic [sfwt_pkg::MODE_W-1:0]       w_in_mode;
    logic [sfwt_pkg::FLAG_W-1:0]       w_in_flag;
    logic                              w_in_value;
    logic [STAMP_WIDTH-1:0]            w_in_stamp;
    logic                              w_in_known;
    logic                              w_report;
    logic [IDX_W-1:0]                  w_rep_idx;
    logic [ENTRIES-1:0]                w_entry_live;
    logic                              w_chk_vld;
    logic [IDX_W-1:0]                  w_chk_idx;
    logic                              w_chk_old;
    logic                              w_expire;
    logic                              w_res_known;
    logic [IDX_W-1:0]                  w_res_base;

    // Input field unpacking.
    assign w_in_mode  = s_axis_tdata[35:32];
    assign w_in_flag  = s_axis_tdata[37:36];
    assign w_in_value = s_axis_tdata[38];
    assign w_in_stamp = STAMP_WIDTH'(s_axis_tdata[31:0]);

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_accept   = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // A mode counts only when it lies inside the table and its mask bit is set.
    assign w_in_known  = ({1'b0, w_in_mode} < LIVE_LIMIT) && r_mode_present[w_in_mode];
    assign w_res_known = ({1'b0, r_mode_id} < LIVE_LIMIT) && r_mode_present[r_mode_id];
    assign w_report    = w_in_accept && (s_axis_tuser == sfwt_pkg::ACT_REPORT) && w_in_known;
    assign w_rep_idx   = IDX_W'({w_in_mode, w_in_flag});

    // Registration of each entry follows its mode's mask bit.
    for (genvar g = 0; g < ENTRIES; g++) begin : g_live
        assign w_entry_live[g] = r_mode_present[g / sfwt_pkg::FLAGS_PER_MODE];
    end

    // Stamp memory and age compare.
    sfwt_age_unit #(
        .ENTRIES     (ENTRIES),
        .STAMP_WIDTH (STAMP_WIDTH)
    ) u_age (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (w_report),
        .i_wr_idx   (w_rep_idx),
        .i_wr_stamp (w_in_stamp),
        .i_rd_en    (r_state == S_SCAN),
        .i_rd_idx   (r_scan_idx),
        .i_now      (r_now),
        .i_timeout  (r_timeout),
        .o_chk_vld  (w_chk_vld),
        .o_chk_idx  (w_chk_idx),
        .o_chk_old  (w_chk_old)
    );

    assign w_expire = w_chk_vld && w_chk_old && w_entry_live[w_chk_idx] && r_fresh[w_chk_idx];

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout      <= sfwt_pkg::TIMEOUT_RESET;
            r_mode_present <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                sfwt_pkg::REG_TIMEOUT:      r_timeout      <= i_cfg_wdata;
                sfwt_pkg::REG_MODE_PRESENT: r_mode_present <= i_cfg_wdata[sfwt_pkg::MASK_W-1:0];
                default: ;
            endcase
        end
    end

    // Fresh bits set and value bits loaded by a report, both cleared when the scan expires them.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fresh <= '0;
            r_value <= '0;
        end else begin
            if (w_report) begin
                r_fresh[w_rep_idx] <= 1'b1;
                r_value[w_rep_idx] <= w_in_value;
            end
            if (w_expire) begin
                r_fresh[w_chk_idx] <= 1'b0;
                r_value[w_chk_idx] <= 1'b0;
            end
        end
    end

    // Item fields kept for the scan and the result.
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_mode_id <= w_in_mode;
            r_now     <= w_in_stamp;
        end
    end

    // Sequencer next state.
    always_comb begin
        n_state    = r_state;
        n_scan_idx = r_scan_idx;
        unique case (r_state)
            S_IDLE: begin
                n_scan_idx = '0;
                if (w_in_accept) begin
                    n_state = (s_axis_tuser == sfwt_pkg::ACT_AGE) ? S_SCAN : S_DONE;
                end
            end
            S_SCAN: begin
                n_scan_idx = r_scan_idx + 1'b1;
                if (r_scan_idx == LAST_IDX) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_DONE;
            S_DONE: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_scan_idx <= '0;
        end else begin
            r_state    <= n_state;
            r_scan_idx <= n_scan_idx;
        end
    end

    // Result of the addressed mode; stale flags read false.
    assign w_res_base            = IDX_W'({r_mode_id, 2'b00});
    assign w_result.available    = w_res_known && r_fresh[w_res_base]
                                   && r_value[w_res_base];
    assign w_result.active       = w_res_known && r_fresh[w_res_base + 1'b1]
                                   && r_value[w_res_base + 1'b1];
    assign w_result.stable       = w_res_known && r_fresh[w_res_base + 2'd2]
                                   && r_value[w_res_base + 2'd2];
    assign w_result.continuable  = w_res_known && r_fresh[w_res_base + 2'd3]
                                   && r_value[w_res_base + 2'd3];
    assign w_result.mode_known   = w_res_known;
    assign w_result.all_ready    = &(r_fresh | ~w_entry_live);

    // Output register, loaded in the done state when it is empty or its transfer completes.
    assign w_out_load = (r_state == S_DONE) && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = sfwt_pkg::M_TDATA_W'(r_out);

    // Checks on the sequencer and the flag table.
    `SFWT_ASSERT_NEXT(a_report_sets_fresh, i_clk, i_rst_n, w_report, r_fresh[$past(w_rep_idx)])
    `SFWT_ASSERT_SAME(a_chk_in_scan, i_clk, i_rst_n, w_chk_vld, (r_state == S_SCAN) || (r_state == S_DRAIN))
    `SFWT_ASSERT_NEXT(a_load_valid, i_clk, i_rst_n, w_out_load, r_out_valid && (r_state == S_IDLE))

endmodule

### test/status_freshness_watchdog_table_unit_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// status_freshness_watchdog_table_unit_tb
// Self-checking bench for the status freshness table. A scoreboard class
// keeps its own copy of the flag table and predicts one status per item;
// directed items cover wrap, strict aging and registration changes, then
// random phases sweep timeouts, masks and handshake idling.
// ---------------------------------------------------------------------------
module status_freshness_watchdog_table_unit_tb;

    import sfwt_pkg::*;

    localparam int ENTRY_COUNT      = MODE_LIMIT * FLAGS_PER_MODE;
    localparam int PHASE_COUNT      = 6;
    localparam int ITEMS_PER_PHASE  = 140;
    localparam int RX_HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES     = 80;
    localparam int LIMIT_NS         = 4_000_000;
    localparam int REPORT_LIMIT     = 10;

    // Register indexes with no register behind them.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    // One input item as the fields of the interface.
    typedef struct {
        logic                action;
        logic [NOW_W-1:0]    now;
        logic [MODE_W-1:0]   mode;
        logic [FLAG_W-1:0]   sel;
        logic                val;
    } t_status_item;

    // -----------------------------------------------------------------------
    // Scoreboard: private flag table, registers and the expected statuses.
    // -----------------------------------------------------------------------
    class flag_table_scoreboard;
        logic [TIMEOUT_W-1:0] timeout_limit;
        logic [MASK_W-1:0]    mode_mask;
        logic [NOW_W-1:0]     stamp [ENTRY_COUNT];
        bit                   fresh [ENTRY_COUNT];
        bit                   level [ENTRY_COUNT];
        t_result              status_expected [$];
        int                   failures;

        function new();
            timeout_limit = TIMEOUT_RESET;
            mode_mask     = '0;
            failures      = 0;
            foreach (fresh[e]) begin
                stamp[e] = '0;
                fresh[e] = 1'b0;
                level[e] = 1'b0;
            end
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [TIMEOUT_W-1:0] data);
            case (idx)
                REG_TIMEOUT:      timeout_limit = data;
                REG_MODE_PRESENT: mode_mask = data[MASK_W-1:0];
                default: ;
            endcase
        endfunction

        // Apply one accepted item to the table and queue the status it yields.
        function void note_item(t_status_item it);
            int              e;
            logic [NOW_W-1:0] elapsed;
            bit              known;
            bit              ready;
            t_result         r;
            known = mode_mask[it.mode];
            if (it.action == ACT_REPORT) begin
                if (known) begin
                    e = it.mode * FLAGS_PER_MODE + it.sel;
                    stamp[e] = it.now;
                    level[e] = it.val;
                    fresh[e] = 1'b1;
                end
            end else begin
                // Age every flag of every registered mode, modulo the stamp width.
                for (int m = 0; m < MODE_LIMIT; m++) begin
                    if (mode_mask[m]) begin
                        for (int f = 0; f < FLAGS_PER_MODE; f++) begin
                            e = m * FLAGS_PER_MODE + f;
                            elapsed = it.now - stamp[e];
                            if (fresh[e] && elapsed > timeout_limit) begin
                                fresh[e] = 1'b0;
                                level[e] = 1'b0;
                            end
                        end
                    end
                end
            end
            ready = 1'b1;
            for (int m = 0; m < MODE_LIMIT; m++) begin
                if (mode_mask[m]) begin
                    for (int f = 0; f < FLAGS_PER_MODE; f++) begin
                        if (!fresh[m * FLAGS_PER_MODE + f])
                            ready = 1'b0;
                    end
                end
            end
            e = it.mode * FLAGS_PER_MODE;
            r.available   = known && fresh[e]     && level[e];
            r.active      = known && fresh[e + 1] && level[e + 1];
            r.stable      = known && fresh[e + 2] && level[e + 2];
            r.continuable = known && fresh[e + 3] && level[e + 3];
            r.mode_known  = known;
            r.all_ready   = ready;
            status_expected.push_back(r);
        endfunction

        // Compare one accepted status with the oldest expectation.
        function void check_status(t_result got);
            t_result exp_status;
            if (status_expected.size() == 0) begin
                if (failures < REPORT_LIMIT)
                    $display("unexpected status %06b (all_ready..available)", got);
                failures++;
            end else begin
                exp_status = status_expected.pop_front();
                if (got.available !== exp_status.available ||
                    got.active !== exp_status.active ||
                    got.stable !== exp_status.stable ||
                    got.continuable !== exp_status.continuable ||
                    got.mode_known !== exp_status.mode_known ||
                    got.all_ready !== exp_status.all_ready) begin
                    if (failures < REPORT_LIMIT)
                        $display("status mismatch: expected %06b got %06b (all_ready..available)",
                                 exp_status, got);
                    failures++;
                end
            end
        endfunction
    endclass

    // -----------------------------------------------------------------------
    // Signals and the block under test.
    // -----------------------------------------------------------------------
    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata;
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_addr;
    logic [TIMEOUT_W-1:0]   i_cfg_wdata;

    flag_table_scoreboard   sb;
    int                     tx_idle_pct;
    int                     rx_idle_pct;
    bit                     rx_hold_req;
    logic [NOW_W-1:0]       time_cursor;
    int                     rr_entry;

    status_freshness_watchdog_table_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // Clock with a 4 ns period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Every status transfer goes to the scoreboard.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_status(t_result'(m_axis_tdata[5:0]));
    end

    // Receiver: random backpressure, plus a long hold-off on request.
    initial begin
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_axis_tready = 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge i_clk);
            end
            m_axis_tready = ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Run limit.
    initial begin
        #(LIMIT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic t_status_item make_item(logic act, logic [NOW_W-1:0] now,
                                               logic [MODE_W-1:0] mode,
                                               logic [FLAG_W-1:0] sel, logic val);
        t_status_item it;
        it.action = act;
        it.now    = now;
        it.mode   = mode;
        it.sel    = sel;
        it.val    = val;
        return it;
    endfunction

    // Offer one item after a random gap and hold it until the transfer.
    task automatic send_item(input t_status_item it);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = it.action;
        s_axis_tdata  = {1'b0, it.val, it.sel, it.mode, it.now};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_item(it);
    endtask

    // Stop offering and wait for every outstanding status.
    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (sb.status_expected.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TIMEOUT_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_addr  = idx;
        i_cfg_wdata = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Any registered mode, or any mode at all when none is registered.
    function automatic logic [MODE_W-1:0] pick_mode();
        logic [MODE_W-1:0] m;
        m = MODE_W'($urandom_range(0, MODE_LIMIT - 1));
        if (sb.mode_mask != '0) begin
            while (!sb.mode_mask[m]) m = MODE_W'($urandom_range(0, MODE_LIMIT - 1));
        end
        return m;
    endfunction

    // Random item: mostly reports to registered flags, some age checks and noise.
    function automatic t_status_item next_random_item();
        t_status_item      it;
        logic [NOW_W-1:0]  span;
        logic [NOW_W-1:0]  step;
        int                pick;
        int                tries;
        // Advance time by a small step, about one timeout, or anything at all.
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            span = (sb.timeout_limit < 64) ? 3 : (sb.timeout_limit >> 4);
            step = $urandom_range(0, span);
        end else if (pick < 85) begin
            step = sb.timeout_limit + $urandom_range(0, 4) - 2;
        end else begin
            step = $urandom();
        end
        time_cursor = time_cursor + step;
        it.now = time_cursor;
        it.sel = FLAG_W'($urandom_range(0, FLAGS_PER_MODE - 1));
        it.val = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            it.action = ACT_AGE;
            it.mode = ($urandom_range(0, 99) < 70) ? pick_mode()
                                                   : MODE_W'($urandom_range(0, MODE_LIMIT - 1));
        end else if (pick < 20) begin
            it.action = ACT_REPORT;
            it.mode = MODE_W'($urandom_range(0, MODE_LIMIT - 1));
        end else begin
            it.action = ACT_REPORT;
            if (sb.mode_mask != '0 && $urandom_range(0, 1) == 1) begin
                // Walk the registered flags in turn so that whole tables fill up.
                tries = 0;
                do begin
                    rr_entry = (rr_entry + 1) % ENTRY_COUNT;
                    tries++;
                end while (!sb.mode_mask[rr_entry / FLAGS_PER_MODE] && tries < ENTRY_COUNT);
                it.mode = MODE_W'(rr_entry / FLAGS_PER_MODE);
                it.sel  = FLAG_W'(rr_entry % FLAGS_PER_MODE);
            end else begin
                it.mode = pick_mode();
            end
            if ($urandom_range(0, 99) < 5)
                it.now = $urandom();
        end
        return it;
    endfunction

    // Mask with one to three random modes.
    function automatic logic [TIMEOUT_W-1:0] few_modes();
        logic [TIMEOUT_W-1:0] mask;
        mask = '0;
        repeat ($urandom_range(1, 3)) mask[$urandom_range(0, MODE_LIMIT - 1)] = 1'b1;
        return mask;
    endfunction

    // -----------------------------------------------------------------------
    // Stimulus and end of run.
    // -----------------------------------------------------------------------
    initial begin
        sb            = new();
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = ACT_REPORT;
        i_cfg_valid   = 1'b0;
        i_cfg_addr    = REG_TIMEOUT;
        i_cfg_wdata   = '0;
        rx_hold_req   = 1'b0;
        tx_idle_pct   = 7;
        rx_idle_pct   = 74;
        rr_entry      = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset settings: no mode registered, so a report is ignored and all are ready.
        send_item(make_item(ACT_REPORT, 32'h0000_0000, 4'd3, 2'd1, 1'b1));
        send_item(make_item(ACT_AGE, 32'hFFFF_FFFF, 4'd15, 2'd3, 1'b1));

        // Modes 0 and 15, spare indexes ignored, short timeout.
        wait_drained();
        write_reg(REG_MODE_PRESENT, 32'hA5A5_8001);
        write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
        write_reg(REG_SPARE_HI, 32'h0000_0000);
        write_reg(REG_TIMEOUT, 32'd10);
        send_item(make_item(ACT_REPORT, 32'hFFFF_FFFA, 4'd0, 2'd0, 1'b1));
        send_item(make_item(ACT_REPORT, 32'hFFFF_FFFA, 4'd0, 2'd1, 1'b0));
        send_item(make_item(ACT_REPORT, 32'hFFFF_FFFA, 4'd0, 2'd2, 1'b1));
        send_item(make_item(ACT_REPORT, 32'hFFFF_FFFA, 4'd0, 2'd3, 1'b1));
        for (int f = 0; f < FLAGS_PER_MODE; f++)
            send_item(make_item(ACT_REPORT, 32'hFFFF_FFFC, 4'd15, FLAG_W'(f), 1'b1));

        // Across the wrap: an age equal to the timeout survives, one more tick expires.
        send_item(make_item(ACT_AGE, 32'h0000_0004, 4'd0, 2'd0, 1'b0));
        send_item(make_item(ACT_AGE, 32'h0000_0005, 4'd0, 2'd2, 1'b1));
        send_item(make_item(ACT_REPORT, 32'h0000_0005, 4'd7, 2'd2, 1'b1));
        send_item(make_item(ACT_REPORT, 32'h0000_0006, 4'd0, 2'd2, 1'b1));

        // Drop mode 0: it is neither aged nor shown while unregistered.
        wait_drained();
        write_reg(REG_MODE_PRESENT, 32'h0000_8000);
        send_item(make_item(ACT_AGE, 32'h0000_1000, 4'd0, 2'd1, 1'b0));

        // Register it again under the largest timeout: its stable flag is back.
        wait_drained();
        write_reg(REG_MODE_PRESENT, 32'h0000_0001);
        write_reg(REG_TIMEOUT, 32'hFFFF_FFFF);
        send_item(make_item(ACT_AGE, 32'h8000_0000, 4'd0, 2'd0, 1'b0));

        // Zero timeout: only flags stamped at the very same tick survive.
        wait_drained();
        write_reg(REG_TIMEOUT, 32'd0);
        send_item(make_item(ACT_REPORT, 32'h8000_0000, 4'd0, 2'd0, 1'b1));
        send_item(make_item(ACT_REPORT, 32'h8000_0000, 4'd0, 2'd1, 1'b1));
        send_item(make_item(ACT_REPORT, 32'h8000_0000, 4'd0, 2'd3, 1'b1));
        send_item(make_item(ACT_AGE, 32'h8000_0000, 4'd0, 2'd3, 1'b0));
        send_item(make_item(ACT_REPORT, 32'h8000_0001, 4'd0, 2'd2, 1'b0));
        send_item(make_item(ACT_AGE, 32'h8000_0001, 4'd0, 2'd1, 1'b1));

        // Random phases, each with its own timeout and set of modes.
        time_cursor = 32'h0000_2000;
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            wait_drained();
            tx_idle_pct = (ph < 2) ? 7 : (ph < 4) ? 74 : 0;
            rx_idle_pct = (ph < 2) ? 74 : (ph < 4) ? 7 : 0;
            case (ph)
                0: begin
                    write_reg(REG_TIMEOUT, 32'd0);
                    write_reg(REG_MODE_PRESENT, 32'h0000_0001);
                end
                1: begin
                    write_reg(REG_TIMEOUT, $urandom_range(2, 40));
                    write_reg(REG_MODE_PRESENT, few_modes());
                end
                2: begin
                    write_reg(REG_TIMEOUT, 32'hFFFF_FFFF);
                    write_reg(REG_MODE_PRESENT, 32'hFFFF_FFFF);
                end
                3: begin
                    write_reg(REG_TIMEOUT, $urandom_range(100, 5000));
                    write_reg(REG_MODE_PRESENT, $urandom());
                    time_cursor = 32'hFFFF_F000;
                end
                4: begin
                    write_reg(REG_TIMEOUT, 32'd1000);
                    write_reg(REG_MODE_PRESENT, few_modes());
                end
                default: begin
                    write_reg(REG_TIMEOUT, $urandom());
                    write_reg(REG_MODE_PRESENT, $urandom());
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                send_item(next_random_item());
                // Back up the output while items keep coming.
                if (ph == 4 && n == 30)
                    rx_hold_req = 1'b1;
                // Let the pipeline empty out completely once mid-stream.
                if (ph == 1 && n == 70)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.failures == 0 && sb.status_expected.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
